@@ src/rclm_pkg.sv @@
// Shared constants, types and control structs for the remote code learn-and-match block.
package rclm_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int NUM_REMOTES = 2;
   localparam int TABLE_SIZE  = NUM_BUTTONS * NUM_REMOTES;

   localparam int REQ_W      = 3;
   localparam int CODE_W     = 32;
   localparam int BUTTON_W   = 4;
   localparam int SLOT_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int CMD_W      = 8;
   localparam int DEBOUNCE_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int MAP_BYTES  = CSR_DATA_W / CMD_W;

   localparam int IDX_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int BTN_CNT_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int SLT_CNT_W = (NUM_REMOTES > 1) ? $clog2(NUM_REMOTES) : 1;

   typedef logic [REQ_W-1:0]      req_code_type;
   typedef logic [CODE_W-1:0]     code_type;
   typedef logic [BUTTON_W-1:0]   button_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [STATUS_W-1:0]   status_code_type;
   typedef logic [CMD_W-1:0]      cmd_byte_type;
   typedef logic [DEBOUNCE_W-1:0] debounce_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [BTN_CNT_W-1:0]  btn_cnt_type;
   typedef logic [SLT_CNT_W-1:0]  slot_cnt_type;

   localparam logic [BUTTON_W:0] BUTTON_LIMIT = (BUTTON_W + 1)'(NUM_BUTTONS);
   localparam logic [SLOT_W:0]   SLOT_LIMIT   = (SLOT_W + 1)'(NUM_REMOTES);
   localparam btn_cnt_type       BTN_LAST     = btn_cnt_type'(NUM_BUTTONS - 1);
   localparam slot_cnt_type      SLOT_LAST    = slot_cnt_type'(NUM_REMOTES - 1);

   // request codes
   localparam req_code_type REQ_RX_CODE      = 3'd0;
   localparam req_code_type REQ_LEARN        = 3'd1;
   localparam req_code_type REQ_CANCEL       = 3'd2;
   localparam req_code_type REQ_CLEAR_ENTRY  = 3'd3;
   localparam req_code_type REQ_CLEAR_BUTTON = 3'd4;
   localparam req_code_type REQ_READ         = 3'd5;

   // result status codes
   localparam status_code_type ST_IGNORED  = 3'd0;
   localparam status_code_type ST_LEARNED  = 3'd1;
   localparam status_code_type ST_MATCHED  = 3'd2;
   localparam status_code_type ST_UNKNOWN  = 3'd3;
   localparam status_code_type ST_DONE     = 3'd4;
   localparam status_code_type ST_REJECTED = 3'd5;

   // configuration register indexes
   localparam csr_idx_type CSR_IS_MASTER   = 2'd0;
   localparam csr_idx_type CSR_DEBOUNCE    = 2'd1;
   localparam csr_idx_type CSR_COMMAND_MAP = 2'd2;

   localparam debounce_type DEBOUNCE_RESET = 16'd200;

   typedef struct packed {
      logic capture;
      logic decide;
      logic scan_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_done;
   } dp_status_type;

endpackage

@@ src/rclm_ctrl.sv @@
// Controller state machine: request handshake, sequencing and result handshake.
module rclm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rclm_pkg::ctrl_cmd_type cmd,
   input  rclm_pkg::dp_status_type sts
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.need_scan ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/rclm_datapath.sv @@
// Datapath: code table, learn state, configuration registers, scan unit and result registers.
module rclm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  rclm_pkg::ctrl_cmd_type        cmd,
   output rclm_pkg::dp_status_type       sts,
   input  rclm_pkg::req_code_type        req_type,
   input  rclm_pkg::code_type            req_rx_code,
   input  rclm_pkg::code_type            req_now_ms,
   input  rclm_pkg::button_type          req_button_index,
   input  rclm_pkg::slot_type            req_slot_index,
   input  logic                          csr_write,
   input  rclm_pkg::csr_idx_type         csr_index,
   input  rclm_pkg::csr_data_type        csr_data,
   output rclm_pkg::status_code_type     rsp_status,
   output rclm_pkg::button_type          rsp_hit_button,
   output rclm_pkg::cmd_byte_type        rsp_command,
   output rclm_pkg::code_type            rsp_code_out,
   output logic                          rsp_learning,
   output rclm_pkg::button_type          rsp_learn_button,
   output rclm_pkg::slot_type            rsp_learn_slot,
   output logic                          rsp_save_request
);

   function automatic rclm_pkg::idx_type entry_index(input rclm_pkg::button_type btn,
                                                     input rclm_pkg::slot_type slot);
      return rclm_pkg::idx_type'(int'(btn) * rclm_pkg::NUM_REMOTES + int'(slot));
   endfunction

   function automatic rclm_pkg::cmd_byte_type map_command(input rclm_pkg::csr_data_type map,
                                                          input rclm_pkg::button_type btn);
      rclm_pkg::cmd_byte_type result;
      result = '0;
      for (int i = 0; i < rclm_pkg::MAP_BYTES; i++) begin
         if (btn == rclm_pkg::button_type'(i)) begin
            result = map[i*rclm_pkg::CMD_W +: rclm_pkg::CMD_W];
         end
      end
      return result;
   endfunction

   // configuration and persistent state
   logic                   is_master_ff, is_master_in;
   rclm_pkg::debounce_type debounce_ff, debounce_in;
   rclm_pkg::csr_data_type cmd_map_ff, cmd_map_in;
   rclm_pkg::code_type     table_ff [rclm_pkg::TABLE_SIZE];
   rclm_pkg::code_type     table_in [rclm_pkg::TABLE_SIZE];
   logic                   learn_armed_ff, learn_armed_in;
   rclm_pkg::button_type   armed_btn_ff, armed_btn_in;
   rclm_pkg::slot_type     armed_slot_ff, armed_slot_in;
   rclm_pkg::code_type     last_ms_ff, last_ms_in;

   // captured request
   rclm_pkg::req_code_type rtype_ff, rtype_in;
   rclm_pkg::code_type     code_ff, code_in;
   rclm_pkg::code_type     now_ff, now_in;
   rclm_pkg::button_type   rbtn_ff, rbtn_in;
   rclm_pkg::slot_type     rslot_ff, rslot_in;

   // scan counters
   rclm_pkg::btn_cnt_type  scan_btn_ff, scan_btn_in;
   rclm_pkg::slot_cnt_type scan_slot_ff, scan_slot_in;

   // staged result
   rclm_pkg::status_code_type res_status_ff, res_status_in;
   rclm_pkg::button_type      res_hit_ff, res_hit_in;
   rclm_pkg::cmd_byte_type    res_cmd_ff, res_cmd_in;
   rclm_pkg::code_type        res_code_ff, res_code_in;
   logic                      res_save_ff, res_save_in;

   // output register
   rclm_pkg::status_code_type rsp_status_ff, rsp_status_in;
   rclm_pkg::button_type      rsp_hit_ff, rsp_hit_in;
   rclm_pkg::cmd_byte_type    rsp_cmd_ff, rsp_cmd_in;
   rclm_pkg::code_type        rsp_code_ff, rsp_code_in;
   logic                      rsp_learning_ff, rsp_learning_in;
   rclm_pkg::button_type      rsp_lbtn_ff, rsp_lbtn_in;
   rclm_pkg::slot_type        rsp_lslot_ff, rsp_lslot_in;
   logic                      rsp_save_ff, rsp_save_in;

   logic                 btn_ok, pair_ok, armed_ok, rx_ok, scan_hit, scan_last;
   rclm_pkg::code_type   elapsed;
   rclm_pkg::idx_type    req_idx, armed_idx, scan_idx, rd_idx;
   rclm_pkg::code_type   rd_data;

   assign btn_ok   = ({1'b0, rbtn_ff} < rclm_pkg::BUTTON_LIMIT);
   assign pair_ok  = btn_ok && ({1'b0, rslot_ff} < rclm_pkg::SLOT_LIMIT);
   assign armed_ok = ({1'b0, armed_btn_ff} < rclm_pkg::BUTTON_LIMIT) &&
                     ({1'b0, armed_slot_ff} < rclm_pkg::SLOT_LIMIT);
   assign elapsed  = now_ff - last_ms_ff;
   assign rx_ok    = (rtype_ff == rclm_pkg::REQ_RX_CODE) && (code_ff != '0) && is_master_ff &&
                     (elapsed >= rclm_pkg::code_type'(debounce_ff));

   assign req_idx   = entry_index(rbtn_ff, rslot_ff);
   assign armed_idx = entry_index(armed_btn_ff, armed_slot_ff);
   assign scan_idx  = entry_index(rclm_pkg::button_type'(scan_btn_ff),
                                  rclm_pkg::slot_type'(scan_slot_ff));

   // single table read port
   assign rd_idx  = cmd.scan_step ? scan_idx : req_idx;
   assign rd_data = ({1'b0, rd_idx} < (rclm_pkg::IDX_W + 1)'(rclm_pkg::TABLE_SIZE)) ?
                    table_ff[rd_idx] : '0;

   assign scan_hit  = (rd_data != '0) && (rd_data == code_ff);
   assign scan_last = (scan_btn_ff == rclm_pkg::BTN_LAST) && (scan_slot_ff == rclm_pkg::SLOT_LAST);

   assign sts.need_scan = rx_ok && !learn_armed_ff;
   assign sts.scan_done = scan_hit || scan_last;

   always_comb begin
      is_master_in    = is_master_ff;
      debounce_in     = debounce_ff;
      cmd_map_in      = cmd_map_ff;
      table_in        = table_ff;
      learn_armed_in  = learn_armed_ff;
      armed_btn_in    = armed_btn_ff;
      armed_slot_in   = armed_slot_ff;
      last_ms_in      = last_ms_ff;
      rtype_in        = rtype_ff;
      code_in         = code_ff;
      now_in          = now_ff;
      rbtn_in         = rbtn_ff;
      rslot_in        = rslot_ff;
      scan_btn_in     = scan_btn_ff;
      scan_slot_in    = scan_slot_ff;
      res_status_in   = res_status_ff;
      res_hit_in      = res_hit_ff;
      res_cmd_in      = res_cmd_ff;
      res_code_in     = res_code_ff;
      res_save_in     = res_save_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_cmd_in      = rsp_cmd_ff;
      rsp_code_in     = rsp_code_ff;
      rsp_learning_in = rsp_learning_ff;
      rsp_lbtn_in     = rsp_lbtn_ff;
      rsp_lslot_in    = rsp_lslot_ff;
      rsp_save_in     = rsp_save_ff;

      if (cmd.capture) begin
         rtype_in = req_type;
         code_in  = req_rx_code;
         now_in   = req_now_ms;
         rbtn_in  = req_button_index;
         rslot_in = req_slot_index;
      end

      if (cmd.decide) begin
         res_status_in = rclm_pkg::ST_IGNORED;
         res_hit_in    = '0;
         res_cmd_in    = '0;
         res_code_in   = '0;
         res_save_in   = 1'b0;
         scan_btn_in   = '0;
         scan_slot_in  = '0;
         unique case (rtype_ff)
            rclm_pkg::REQ_RX_CODE: begin
               if (rx_ok) begin
                  last_ms_in = now_ff;
                  if (learn_armed_ff) begin
                     if (armed_ok) begin
                        table_in[armed_idx] = code_ff;
                     end
                     learn_armed_in = 1'b0;
                     res_save_in    = 1'b1;
                     res_status_in  = rclm_pkg::ST_LEARNED;
                  end else begin
                     // miss unless the scan finds the code
                     res_status_in = rclm_pkg::ST_UNKNOWN;
                  end
               end
            end
            rclm_pkg::REQ_LEARN: begin
               if (is_master_ff) begin
                  if (!pair_ok) begin
                     res_status_in = rclm_pkg::ST_REJECTED;
                  end else begin
                     learn_armed_in = 1'b1;
                     armed_btn_in   = rbtn_ff;
                     armed_slot_in  = rslot_ff;
                     res_status_in  = rclm_pkg::ST_DONE;
                  end
               end
            end
            rclm_pkg::REQ_CANCEL: begin
               learn_armed_in = 1'b0;
               res_status_in  = rclm_pkg::ST_DONE;
            end
            rclm_pkg::REQ_CLEAR_ENTRY: begin
               if (!pair_ok) begin
                  res_status_in = rclm_pkg::ST_REJECTED;
               end else begin
                  table_in[req_idx] = '0;
                  res_status_in     = rclm_pkg::ST_DONE;
               end
            end
            rclm_pkg::REQ_CLEAR_BUTTON: begin
               if (!btn_ok) begin
                  res_status_in = rclm_pkg::ST_REJECTED;
               end else begin
                  for (int b = 0; b < rclm_pkg::NUM_BUTTONS; b++) begin
                     for (int s = 0; s < rclm_pkg::NUM_REMOTES; s++) begin
                        if (rbtn_ff == rclm_pkg::button_type'(b)) begin
                           table_in[b*rclm_pkg::NUM_REMOTES + s] = '0;
                        end
                     end
                  end
                  res_status_in = rclm_pkg::ST_DONE;
               end
            end
            rclm_pkg::REQ_READ: begin
               if (!pair_ok) begin
                  res_status_in = rclm_pkg::ST_REJECTED;
               end else begin
                  res_code_in   = rd_data;
                  res_status_in = rclm_pkg::ST_DONE;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan_step) begin
         if (scan_hit) begin
            res_status_in = rclm_pkg::ST_MATCHED;
            res_hit_in    = rclm_pkg::button_type'(scan_btn_ff);
            res_cmd_in    = map_command(cmd_map_ff, rclm_pkg::button_type'(scan_btn_ff));
         end else if (scan_slot_ff == rclm_pkg::SLOT_LAST) begin
            // advance to the next button
            scan_slot_in = '0;
            scan_btn_in  = scan_btn_ff + 1'b1;
         end else begin
            scan_slot_in = scan_slot_ff + 1'b1;
         end
      end

      if (cmd.load_out) begin
         rsp_status_in   = res_status_ff;
         rsp_hit_in      = res_hit_ff;
         rsp_cmd_in      = res_cmd_ff;
         rsp_code_in     = res_code_ff;
         rsp_learning_in = learn_armed_ff;
         rsp_lbtn_in     = armed_btn_ff;
         rsp_lslot_in    = armed_slot_ff;
         rsp_save_in     = res_save_ff;
      end

      if (csr_write) begin
         unique case (csr_index)
            rclm_pkg::CSR_IS_MASTER:   is_master_in = csr_data[0];
            rclm_pkg::CSR_DEBOUNCE:    debounce_in  = csr_data[rclm_pkg::DEBOUNCE_W-1:0];
            rclm_pkg::CSR_COMMAND_MAP: cmd_map_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_master_ff   <= 1'b1;
         debounce_ff    <= rclm_pkg::DEBOUNCE_RESET;
         cmd_map_ff     <= '0;
         for (int i = 0; i < rclm_pkg::TABLE_SIZE; i++) begin
            table_ff[i] <= '0;
         end
         learn_armed_ff <= 1'b0;
         armed_btn_ff   <= '0;
         armed_slot_ff  <= '0;
         last_ms_ff     <= '0;
      end else begin
         is_master_ff   <= is_master_in;
         debounce_ff    <= debounce_in;
         cmd_map_ff     <= cmd_map_in;
         table_ff       <= table_in;
         learn_armed_ff <= learn_armed_in;
         armed_btn_ff   <= armed_btn_in;
         armed_slot_ff  <= armed_slot_in;
         last_ms_ff     <= last_ms_in;
      end
   end

   always_ff @(posedge clock) begin
      rtype_ff        <= rtype_in;
      code_ff         <= code_in;
      now_ff          <= now_in;
      rbtn_ff         <= rbtn_in;
      rslot_ff        <= rslot_in;
      scan_btn_ff     <= scan_btn_in;
      scan_slot_ff    <= scan_slot_in;
      res_status_ff   <= res_status_in;
      res_hit_ff      <= res_hit_in;
      res_cmd_ff      <= res_cmd_in;
      res_code_ff     <= res_code_in;
      res_save_ff     <= res_save_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_cmd_ff      <= rsp_cmd_in;
      rsp_code_ff     <= rsp_code_in;
      rsp_learning_ff <= rsp_learning_in;
      rsp_lbtn_ff     <= rsp_lbtn_in;
      rsp_lslot_ff    <= rsp_lslot_in;
      rsp_save_ff     <= rsp_save_in;
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_hit_button   = rsp_hit_ff;
   assign rsp_command      = rsp_cmd_ff;
   assign rsp_code_out     = rsp_code_ff;
   assign rsp_learning     = rsp_learning_ff;
   assign rsp_learn_button = rsp_lbtn_ff;
   assign rsp_learn_slot   = rsp_lslot_ff;
   assign rsp_save_request = rsp_save_ff;

endmodule

@@ src/remote_code_learn_and_match.sv @@
// Top level of the remote code learn-and-match block: controller beside datapath.
// A taken request is captured, decided and loaded into the output register once that is free;
// a received code that scans the table passes the scan first (one table entry compared per cycle,
// button then slot, over up to eight entries). New requests stall until the last result is loaded.
// A finished result waits in the output register while the next request is taken in.
// Reset (sync, active high) clears table and learn state; master on, 200 ms debounce, map zero.
module remote_code_learn_and_match (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rclm_pkg::req_code_type    req_type,
   input  rclm_pkg::code_type        req_rx_code,
   input  rclm_pkg::code_type        req_now_ms,
   input  rclm_pkg::button_type      req_button_index,
   input  rclm_pkg::slot_type        req_slot_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rclm_pkg::status_code_type rsp_status,
   output rclm_pkg::button_type      rsp_hit_button,
   output rclm_pkg::cmd_byte_type    rsp_command,
   output rclm_pkg::code_type        rsp_code_out,
   output logic                      rsp_learning,
   output rclm_pkg::button_type      rsp_learn_button,
   output rclm_pkg::slot_type        rsp_learn_slot,
   output logic                      rsp_save_request,
   input  logic                      csr_write,
   input  rclm_pkg::csr_idx_type     csr_index,
   input  rclm_pkg::csr_data_type    csr_data
);

   rclm_pkg::ctrl_cmd_type  cmd;
   rclm_pkg::dp_status_type sts;

   rclm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   rclm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_rx_code      (req_rx_code),
      .req_now_ms       (req_now_ms),
      .req_button_index (req_button_index),
      .req_slot_index   (req_slot_index),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_status       (rsp_status),
      .rsp_hit_button   (rsp_hit_button),
      .rsp_command      (rsp_command),
      .rsp_code_out     (rsp_code_out),
      .rsp_learning     (rsp_learning),
      .rsp_learn_button (rsp_learn_button),
      .rsp_learn_slot   (rsp_learn_slot),
      .rsp_save_request (rsp_save_request)
   );

endmodule
